@@ hw/rtl/wes_pkg.sv @@
// Shared constants, types and helpers for the wave equation stencil step block.
package wes_pkg;

	// Sample format: signed fixed point with 16 fraction bits.
	localparam int VALUE_BITS    = 24;
	localparam int COURANT_BITS  = 32;
	localparam int INDEX_BITS    = 8;
	localparam int MAX_POINTS    = 2 ** INDEX_BITS;

	// Stencil arithmetic widths: the difference and base need two guard bits,
	// the final sum one more.
	localparam int WIDE_BITS     = VALUE_BITS + 2;
	localparam int SUM_BITS      = VALUE_BITS + 3;
	localparam int PROD_BITS     = WIDE_BITS + COURANT_BITS;

	// Result queue and in-flight bookkeeping.
	localparam int FIFO_DEPTH    = 16;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;
	localparam int PIPE_STAGES   = 4;
	localparam int PEND_BITS     = $clog2(PIPE_STAGES + 1);

	// Configuration register reset values and limits.
	localparam logic [COURANT_BITS-1:0] COURANT_RESET    = 32'd7358;
	localparam logic [INDEX_BITS-1:0]   LAST_INDEX_RESET = 8'd191;
	localparam logic [INDEX_BITS-1:0]   MIN_LAST_INDEX   = 8'd2;

	// Register index as decoded from the APB address.
	typedef enum logic {
		REG_COURANT    = 1'b0,
		REG_LAST_INDEX = 1'b1
	} wes_reg_t;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	// What results an item produces once its stencil value is ready.
	typedef struct packed {
		logic first_zero;  // zero value for the first grid point
		logic stencil;     // computed interior value
		logic row_end;     // zero value for the final grid point
	} wes_emit_t;

	// One result item as held in the output queue.
	typedef struct packed {
		logic   row_end;
		value_t value;
	} wes_result_t;

	// Clamp a wide sum to the signed sample range.
	function automatic value_t wes_saturate(input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-VALUE_BITS:0] top;
		top = v[SUM_BITS-1:VALUE_BITS-1];
		if ((&top) || !(|top)) begin
			return v[VALUE_BITS-1:0];
		end else if (v[SUM_BITS-1]) begin
			return {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

@@ hw/rtl/wes_cell.sv @@
// One cell of the sample window: holds a sample and hands it to its neighbor.
module wes_cell import wes_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  value_t din,
	output value_t dout
);

	value_t sample_q;

	// The cell takes its upstream neighbor's sample whenever an item enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= din;
		end
	end

	assign dout = sample_q;

endmodule

@@ hw/rtl/wes_stencil.sv @@
// Four-stage pipeline that evaluates the leapfrog stencil for one point.
module wes_stencil import wes_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  wes_emit_t               in_emit,
	input  value_t                  left,
	input  value_t                  mid,
	input  value_t                  right,
	input  logic                    prev_bypass,
	input  value_t                  prev_mem,     // memory read data, aligned to stage 1
	input  logic [COURANT_BITS-1:0] courant,
	output logic                    out_valid,
	output wes_emit_t               out_emit,
	output value_t                  out_value
);

	// Stage 1: operands of the item that just entered.
	logic      v_s1;
	wes_emit_t emit_s1;
	value_t    left_s1, mid_s1, right_s1;
	logic      byp_s1;

	// Stage 2: difference magnitude and base term.
	logic                        v_s2;
	wes_emit_t                   emit_s2;
	logic                        neg_s2;
	logic [WIDE_BITS-1:0]        mag_s2;
	logic signed [WIDE_BITS-1:0] base_s2;

	// Stage 3: product with the squared Courant number.
	logic                        v_s3;
	wes_emit_t                   emit_s3;
	logic                        neg_s3;
	logic [PROD_BITS-1:0]        prod_s3;
	logic signed [WIDE_BITS-1:0] base_s3;

	// Stage 4: saturated result.
	logic      v_s4;
	wes_emit_t emit_s4;
	value_t    value_s4;

	// Stage 1 arithmetic.
	value_t                      old_val;
	logic signed [WIDE_BITS-1:0] diff;
	logic signed [WIDE_BITS-1:0] base;
	logic [WIDE_BITS-1:0]        mag;

	// Stage 3 arithmetic.
	logic [WIDE_BITS-1:0]        rounded;
	logic signed [SUM_BITS-1:0]  scaled;
	logic signed [SUM_BITS-1:0]  total;

	// The previous layer value comes straight from the window when the item
	// before was a priming item that has not reached memory yet.
	assign old_val = byp_s1 ? mid_s1 : prev_mem;

	always_comb begin
		diff = {{2{left_s1[VALUE_BITS-1]}}, left_s1}
		     + {{2{right_s1[VALUE_BITS-1]}}, right_s1}
		     - {mid_s1[VALUE_BITS-1], mid_s1, 1'b0};
		base = {mid_s1[VALUE_BITS-1], mid_s1, 1'b0}
		     - {{2{old_val[VALUE_BITS-1]}}, old_val};
		mag  = diff[WIDE_BITS-1] ? WIDE_BITS'(-diff) : WIDE_BITS'(diff);
	end

	// Round the product to nearest, halves away from zero, then restore sign.
	always_comb begin
		rounded = prod_s3[PROD_BITS-1:COURANT_BITS]
		        + WIDE_BITS'(prod_s3[COURANT_BITS-1]);
		scaled  = neg_s3 ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
		total   = {base_s3[WIDE_BITS-1], base_s3} + scaled;
	end

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		emit_s1  <= in_emit;
		left_s1  <= left;
		mid_s1   <= mid;
		right_s1 <= right;
		byp_s1   <= prev_bypass;

		emit_s2  <= emit_s1;
		neg_s2   <= diff[WIDE_BITS-1];
		mag_s2   <= mag;
		base_s2  <= base;

		emit_s3  <= emit_s2;
		neg_s3   <= neg_s2;
		prod_s3  <= PROD_BITS'(mag_s2) * PROD_BITS'(courant);
		base_s3  <= base_s2;

		emit_s4  <= emit_s3;
		value_s4 <= wes_saturate(total);
	end

	assign out_valid = v_s4;
	assign out_emit  = emit_s4;
	assign out_value = value_s4;

endmodule

@@ hw/rtl/wes_out_fifo.sv @@
// Result queue that takes up to two items per cycle and gives one per cycle.
module wes_out_fifo import wes_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push0,
	input  logic                     push1,      // only together with push0
	input  wes_result_t              entry0,
	input  wes_result_t              entry1,
	input  logic                     pop,
	output logic                     out_valid,
	output wes_result_t              out_entry,
	output logic [FIFO_CNT_BITS-1:0] count
);

	wes_result_t              store_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] head_q, tail_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic [1:0]               n_push;
	logic                     do_pop;

	assign n_push = {1'b0, push0} + {1'b0, push1};
	assign do_pop = pop && (count_q != '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push0) begin
			store_q[tail_q] <= entry0;
		end
		if (push1) begin
			store_q[tail_q + FIFO_PTR_BITS'(1)] <= entry1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + FIFO_PTR_BITS'(n_push);
			head_q  <= head_q + FIFO_PTR_BITS'(do_pop);
			count_q <= count_q + FIFO_CNT_BITS'(n_push) - FIFO_CNT_BITS'(do_pop);
		end
	end

	assign out_valid = (count_q != '0);
	assign out_entry = store_q[head_q];
	assign count     = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(FIFO_CNT_BITS'(n_push) <= FIFO_CNT_BITS'(FIFO_DEPTH) - count_q))
		else $error("result queue overflow");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second entry pushed without the first");

endmodule

@@ hw/rtl/wave_equation_stencil_step_top.sv @@
// Top level of the streaming explicit 1D wave equation step.
//
// The block takes one grid point of the current layer per cycle, points 0 to
// last_index in order, and returns the next layer in the same order: a zero
// for point 0, nothing for point 1, then the value for point p-1 with each
// point p >= 2, plus a zero marked with tlast after the final point. Items
// with tuser set only load the previous-layer memory. Sustained rate is one
// item per cycle, set by the single read and single write that each item
// makes to the 256-entry previous-layer memory; the write that the final
// point would need is deferred to the slot of the next layer's point 0. A
// result passes through the four stencil stages and the result queue before it
// leaves the output. s_tready drops only while the 16-entry result queue could
// not take the results of the items still in the pipeline plus the new one. The
// memory needs no clearing after reset: a layer must be primed first.
module wave_equation_stencil_step_top import wes_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,

	// Input items.
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [VALUE_BITS-1:0]   s_tdata,   // [23:0] sample
	input  logic                    s_tuser,   // [0] prime

	// Result items.
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [VALUE_BITS-1:0]   m_tdata,   // [23:0] next_value
	output logic                    m_tlast,   // row_end

	// Configuration.
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	// Configuration registers.
	logic [COURANT_BITS-1:0] courant_q;
	logic [INDEX_BITS-1:0]   last_index_q;
	wes_reg_t                reg_sel;
	logic                    cfg_write;

	// Point sequencing.
	logic [INDEX_BITS-1:0]   pt_idx_q;
	logic [INDEX_BITS-1:0]   lim;
	logic                    final_pt;
	logic                    accept;
	logic                    prime;
	value_t                  sample;
	wes_emit_t               emit;

	// Window cells.
	value_t                  win_newer, win_older;

	// Previous-layer memory and deferred final-point write.
	value_t                  prev_mem [MAX_POINTS];
	value_t                  mem_rdata_q;
	logic [INDEX_BITS-1:0]   rd_addr, wr_addr;
	logic                    wr_en;
	logic                    wrap_pend_q;
	logic [INDEX_BITS-1:0]   wrap_addr_q;
	logic                    prev_prime_q;

	// Pipeline and result queue.
	logic                    st_valid;
	wes_emit_t               st_emit;
	value_t                  st_value;
	logic [PEND_BITS-1:0]    pend_q;
	logic                    push0, push1;
	wes_result_t             entry0, entry1, first_res, end_res, out_entry;
	logic [FIFO_CNT_BITS-1:0] fifo_count;
	logic [FIFO_CNT_BITS+1:0] committed;

	// APB access: always ready, register chosen by address bit 2.
	assign pready    = 1'b1;
	assign reg_sel   = wes_reg_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_sel)
			REG_COURANT:    prdata = courant_q;
			REG_LAST_INDEX: prdata = {{(32-INDEX_BITS){1'b0}}, last_index_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q    <= COURANT_RESET;
			last_index_q <= LAST_INDEX_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_COURANT:    courant_q    <= pwdata[COURANT_BITS-1:0];
				REG_LAST_INDEX: last_index_q <= pwdata[INDEX_BITS-1:0];
				default:        ;
			endcase
		end
	end

	// Item decode: which results this point produces and whether it ends the row.
	assign accept   = s_tvalid && s_tready;
	assign prime    = s_tuser;
	assign sample   = s_tdata;
	assign lim      = (last_index_q < MIN_LAST_INDEX) ? MIN_LAST_INDEX : last_index_q;
	assign final_pt = (pt_idx_q >= lim);

	always_comb begin
		emit.first_zero = !prime && (pt_idx_q == '0);
		emit.stencil    = !prime && (pt_idx_q >= INDEX_BITS'(2));
		emit.row_end    = !prime && (pt_idx_q != '0) && final_pt;
	end

	// Point index, deferred final write and priming bypass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_idx_q     <= '0;
			wrap_pend_q  <= 1'b0;
			wrap_addr_q  <= '0;
			prev_prime_q <= 1'b0;
		end else if (accept) begin
			pt_idx_q     <= final_pt ? '0 : pt_idx_q + INDEX_BITS'(1);
			prev_prime_q <= prime;
			if (final_pt) begin
				wrap_pend_q <= 1'b1;
				wrap_addr_q <= pt_idx_q;
			end else if (pt_idx_q == '0) begin
				wrap_pend_q <= 1'b0;
			end
		end
	end

	// Two-cell sample window: newer takes the sample, older takes newer.
	wes_cell u_cell_newer (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (accept),
		.din      (sample),
		.dout     (win_newer)
	);

	wes_cell u_cell_older (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (accept),
		.din      (win_newer),
		.dout     (win_older)
	);

	// Memory: read the previous layer at p-1, then store the window's newer
	// sample there; point 0 uses the write slot for the last row's final point.
	assign rd_addr = pt_idx_q - INDEX_BITS'(1);
	assign wr_addr = (pt_idx_q == '0) ? wrap_addr_q : rd_addr;
	assign wr_en   = accept && ((pt_idx_q != '0) || wrap_pend_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_rdata_q <= prev_mem[rd_addr];
		end
		if (wr_en) begin
			prev_mem[wr_addr] <= win_newer;
		end
	end

	// Stencil pipeline.
	wes_stencil u_stencil (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (accept),
		.in_emit     (emit),
		.left        (win_older),
		.mid         (win_newer),
		.right       (sample),
		.prev_bypass (prev_prime_q),
		.prev_mem    (mem_rdata_q),
		.courant     (courant_q),
		.out_valid   (st_valid),
		.out_emit    (st_emit),
		.out_value   (st_value)
	);

	// Items in flight inside the stencil pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + PEND_BITS'(accept) - PEND_BITS'(st_valid);
		end
	end

	// Results of one item: the first-point zero or the stencil value, then
	// the final-point zero.
	always_comb begin
		first_res.row_end = 1'b0;
		first_res.value   = st_emit.first_zero ? '0 : st_value;
		end_res.row_end   = 1'b1;
		end_res.value     = '0;
		if (st_emit.first_zero || st_emit.stencil) begin
			push0  = st_valid;
			push1  = st_valid && st_emit.row_end;
			entry0 = first_res;
			entry1 = end_res;
		end else begin
			push0  = st_valid && st_emit.row_end;
			push1  = 1'b0;
			entry0 = end_res;
			entry1 = end_res;
		end
	end

	wes_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.entry0    (entry0),
		.entry1    (entry1),
		.pop       (m_tready),
		.out_valid (m_tvalid),
		.out_entry (out_entry),
		.count     (fifo_count)
	);

	assign m_tdata = out_entry.value;
	assign m_tlast = out_entry.row_end;

	// Accept while the queue can hold two results for every item in flight
	// plus the new one.
	assign committed = (FIFO_CNT_BITS+2)'(fifo_count) + ((FIFO_CNT_BITS+2)'(pend_q) << 1);
	assign s_tready  = (committed <= (FIFO_CNT_BITS+2)'(FIFO_DEPTH - 2));

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_pt) |=> (pt_idx_q == '0 && wrap_pend_q))
		else $error("final point did not wrap the index");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 st_valid)
		else $error("stencil result missing four cycles after an item");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_BITS'(PIPE_STAGES))
		else $error("more items in flight than pipeline stages");

endmodule
